@@ design/i2cbm_pkg.sv @@
// shared types and constants of the i2c register burst master
`timescale 1ns / 1ps
`default_nettype none

package i2cbm_pkg;

   localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd104;
   localparam logic [15:0] PHASE_TICKS_RESET    = 16'd100;

   // csr register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_PHASE_TICKS    = 1'b1;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'd0,
      ST_START_A = 4'd1,
      ST_START_B = 4'd2,
      ST_START_C = 4'd3,
      ST_TX_LO   = 4'd4,
      ST_TX_HI   = 4'd5,
      ST_TACK_LO = 4'd6,
      ST_TACK_HI = 4'd7,
      ST_RX_LO   = 4'd8,
      ST_RX_HI   = 4'd9,
      ST_RACK_LO = 4'd10,
      ST_RACK_HI = 4'd11,
      ST_STOP_A  = 4'd12,
      ST_STOP_B  = 4'd13,
      ST_STOP_C  = 4'd14
   } state_type;

   typedef enum logic [1:0] {
      STAGE_ADDR_W = 2'd0,
      STAGE_REG    = 2'd1,
      STAGE_DATA   = 2'd2,
      STAGE_ADDR_R = 2'd3
   } stage_type;

   typedef struct packed {
      logic       command_valid;
      logic       operation;
      logic [7:0] register_address;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       busy_res;
      logic       write_byte_taken;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_last;
      logic       nack_seen;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ design/i2c_register_burst_master.sv @@
// top level: csr block, request queue, bus engine and response queue
`timescale 1ns / 1ps
`default_nettype none

// flow: an accepted request is registered in the request queue; the engine steps on
//   the queue head and writes its response into the response queue at that same edge,
//   and the rsp ports show the head of the response queue
// throughput: one request per cycle while the response queue has room; each
//   request yields exactly one response, two-entry queues on both sides
// reset (synchronous): both queues empty, engine idle with scl and sda released,
//   device_address back to 104 and phase_ticks to 100

module i2c_register_burst_master (
   input  wire logic        clock,
   input  wire logic        reset,

   // request channel
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_command_valid,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_register_address,
   input  wire logic [7:0]  req_byte_count,
   input  wire logic [7:0]  req_write_byte,
   input  wire logic        req_sda_in,

   // response channel
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_scl_level,
   output logic             rsp_sda_release,
   output logic             rsp_busy_res,
   output logic             rsp_write_byte_taken,
   output logic             rsp_read_valid,
   output logic [7:0]       rsp_read_byte,
   output logic             rsp_read_last,
   output logic             rsp_nack_seen,

   // csr port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // csr registers
   logic [6:0]  dev_addr_ff;
   logic [15:0] phase_ticks_ff;
   logic        csr_wr;
   logic        csr_index;

   i2cbm_pkg::req_type          req_in_data;
   i2cbm_pkg::req_type          req_head;
   i2cbm_pkg::queue_status_type req_status;
   i2cbm_pkg::rsp_type          rsp_new;
   i2cbm_pkg::rsp_type          rsp_head;
   i2cbm_pkg::queue_status_type rsp_status;
   logic                        step;

   // access phase write, register picked by the word address bit
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= i2cbm_pkg::DEVICE_ADDRESS_RESET;
         phase_ticks_ff <= i2cbm_pkg::PHASE_TICKS_RESET;
      end else if (csr_wr) begin
         if (csr_index == i2cbm_pkg::CSR_DEVICE_ADDRESS) begin
            dev_addr_ff <= csr_pwdata[6:0];
         end else begin
            phase_ticks_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      if (csr_index == i2cbm_pkg::CSR_PHASE_TICKS) begin
         csr_prdata = {16'd0, phase_ticks_ff};
      end else begin
         csr_prdata = {25'd0, dev_addr_ff};
      end
   end

   // front: gather request fields and queue them
   assign req_in_data.command_valid    = req_command_valid;
   assign req_in_data.operation        = req_operation;
   assign req_in_data.register_address = req_register_address;
   assign req_in_data.byte_count       = req_byte_count;
   assign req_in_data.write_byte       = req_write_byte;
   assign req_in_data.sda_in           = req_sda_in;
   assign req_full                     = req_status.full;

   i2cbm_req_queue u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_in_data),
      .pop       (step),
      .head      (req_head),
      .status    (req_status)
   );

   // engine steps once a request waits and the response queue has room
   assign step = !req_status.empty && !rsp_status.full;

   i2cbm_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .req            (req_head),
      .device_address (dev_addr_ff),
      .phase_ticks    (phase_ticks_ff),
      .rsp            (rsp_new)
   );

   // back: responses wait here until popped
   i2cbm_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (rsp_new),
      .pop       (rsp_pop),
      .head      (rsp_head),
      .status    (rsp_status)
   );

   assign rsp_empty            = rsp_status.empty;
   assign rsp_scl_level        = rsp_head.scl_level;
   assign rsp_sda_release      = rsp_head.sda_release;
   assign rsp_busy_res         = rsp_head.busy_res;
   assign rsp_write_byte_taken = rsp_head.write_byte_taken;
   assign rsp_read_valid       = rsp_head.read_valid;
   assign rsp_read_byte        = rsp_head.read_byte;
   assign rsp_read_last        = rsp_head.read_last;
   assign rsp_nack_seen        = rsp_head.nack_seen;

endmodule

`default_nettype wire

@@ design/i2cbm_req_queue.sv @@
// two-entry request queue in front of the bus engine
`timescale 1ns / 1ps
`default_nettype none

module i2cbm_req_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire i2cbm_pkg::req_type        push_data,
   input  wire logic                      pop,
   output i2cbm_pkg::req_type             head,
   output i2cbm_pkg::queue_status_type    status
);

   i2cbm_pkg::req_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ design/i2cbm_rsp_queue.sv @@
// two-entry response queue behind the bus engine
`timescale 1ns / 1ps
`default_nettype none

module i2cbm_rsp_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire i2cbm_pkg::rsp_type        push_data,
   input  wire logic                      pop,
   output i2cbm_pkg::rsp_type             head,
   output i2cbm_pkg::queue_status_type    status
);

   i2cbm_pkg::rsp_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ design/i2cbm_engine.sv @@
// bus engine: one tick of the i2c waveform sequencer per request
`timescale 1ns / 1ps
`default_nettype none

module i2cbm_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire i2cbm_pkg::req_type  req,
   input  wire logic [6:0]          device_address,
   input  wire logic [15:0]         phase_ticks,
   output i2cbm_pkg::rsp_type       rsp
);

   i2cbm_pkg::state_type state_ff, state_in;
   i2cbm_pkg::stage_type stage_ff, stage_in;
   logic [15:0] phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  bytes_ff, bytes_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  sreg_ff, sreg_in;
   logic        sop_ff, sop_in;
   logic        clock_line_ff, clock_line_in;
   logic        data_line_ff, data_line_in;

   logic [15:0] plen;
   logic [15:0] phase_inc;
   logic        do_enter;
   logic        taken, rvalid, rlast, nack;
   logic [7:0]  rbyte;

   assign plen      = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
   assign phase_inc = phase_ff + 16'd1;

   always_comb begin
      state_in      = state_ff;
      stage_in      = stage_ff;
      phase_in      = phase_ff;
      bit_in        = bit_ff;
      bytes_in      = bytes_ff;
      shift_in      = shift_ff;
      sreg_in       = sreg_ff;
      sop_in        = sop_ff;
      clock_line_in = clock_line_ff;
      data_line_in  = data_line_ff;
      do_enter      = 1'b0;
      taken         = 1'b0;
      rvalid        = 1'b0;
      rbyte         = 8'd0;
      rlast         = 1'b0;
      nack          = 1'b0;

      if (state_ff == i2cbm_pkg::ST_IDLE) begin
         if (req.command_valid) begin
            sop_in   = req.operation;
            sreg_in  = req.register_address;
            bytes_in = req.byte_count;
            stage_in = i2cbm_pkg::STAGE_ADDR_W;
            bit_in   = 4'd0;
            state_in = i2cbm_pkg::ST_START_A;
            do_enter = 1'b1;
         end
      end else begin
         phase_in = phase_inc;
         if (phase_inc >= plen) begin
            do_enter = 1'b1;
            case (state_ff)
               i2cbm_pkg::ST_START_A: state_in = i2cbm_pkg::ST_START_B;
               i2cbm_pkg::ST_START_B: state_in = i2cbm_pkg::ST_START_C;
               i2cbm_pkg::ST_START_C: begin
                  shift_in = {device_address, stage_ff == i2cbm_pkg::STAGE_ADDR_R};
                  bit_in   = 4'd0;
                  state_in = i2cbm_pkg::ST_TX_LO;
               end
               i2cbm_pkg::ST_TX_LO: state_in = i2cbm_pkg::ST_TX_HI;
               i2cbm_pkg::ST_TX_HI: begin
                  bit_in   = bit_ff + 4'd1;
                  state_in = (bit_in >= 4'd8) ? i2cbm_pkg::ST_TACK_LO : i2cbm_pkg::ST_TX_LO;
               end
               i2cbm_pkg::ST_TACK_LO: state_in = i2cbm_pkg::ST_TACK_HI;
               i2cbm_pkg::ST_TACK_HI: begin
                  nack = req.sda_in;
                  if (stage_ff == i2cbm_pkg::STAGE_ADDR_W) begin
                     stage_in = i2cbm_pkg::STAGE_REG;
                     shift_in = sreg_ff;
                     bit_in   = 4'd0;
                     state_in = i2cbm_pkg::ST_TX_LO;
                  end else if (stage_ff == i2cbm_pkg::STAGE_REG &&
                               sop_ff == i2cbm_pkg::OP_READ) begin
                     // repeated start: drive clock low, then release data first
                     stage_in      = i2cbm_pkg::STAGE_ADDR_R;
                     clock_line_in = 1'b0;
                     state_in      = i2cbm_pkg::ST_START_A;
                  end else if (stage_ff == i2cbm_pkg::STAGE_ADDR_R) begin
                     if (bytes_ff != 8'd0) begin
                        shift_in = 8'd0;
                        bit_in   = 4'd0;
                        state_in = i2cbm_pkg::ST_RX_LO;
                     end else begin
                        state_in = i2cbm_pkg::ST_STOP_A;
                     end
                  end else begin
                     if (bytes_ff != 8'd0) begin
                        stage_in = i2cbm_pkg::STAGE_DATA;
                        bytes_in = bytes_ff - 8'd1;
                        taken    = 1'b1;
                        shift_in = req.write_byte;
                        bit_in   = 4'd0;
                        state_in = i2cbm_pkg::ST_TX_LO;
                     end else begin
                        state_in = i2cbm_pkg::ST_STOP_A;
                     end
                  end
               end
               i2cbm_pkg::ST_RX_LO: state_in = i2cbm_pkg::ST_RX_HI;
               i2cbm_pkg::ST_RX_HI: begin
                  shift_in = {shift_ff[6:0], req.sda_in};
                  bit_in   = bit_ff + 4'd1;
                  if (bit_in >= 4'd8) begin
                     bytes_in = bytes_ff - 8'd1;
                     rvalid   = 1'b1;
                     rbyte    = shift_in;
                     rlast    = (bytes_in == 8'd0);
                     state_in = i2cbm_pkg::ST_RACK_LO;
                  end else begin
                     state_in = i2cbm_pkg::ST_RX_LO;
                  end
               end
               i2cbm_pkg::ST_RACK_LO: state_in = i2cbm_pkg::ST_RACK_HI;
               i2cbm_pkg::ST_RACK_HI: begin
                  if (bytes_ff != 8'd0) begin
                     shift_in = 8'd0;
                     bit_in   = 4'd0;
                     state_in = i2cbm_pkg::ST_RX_LO;
                  end else begin
                     state_in = i2cbm_pkg::ST_STOP_A;
                  end
               end
               i2cbm_pkg::ST_STOP_A: state_in = i2cbm_pkg::ST_STOP_B;
               i2cbm_pkg::ST_STOP_B: state_in = i2cbm_pkg::ST_STOP_C;
               default: state_in = i2cbm_pkg::ST_IDLE;
            endcase
         end
      end

      // line levels set on entry to a segment
      if (do_enter) begin
         phase_in = 16'd0;
         case (state_in)
            i2cbm_pkg::ST_START_A: data_line_in = 1'b1;
            i2cbm_pkg::ST_START_B: clock_line_in = 1'b1;
            i2cbm_pkg::ST_START_C: data_line_in = 1'b0;
            i2cbm_pkg::ST_TX_LO: begin
               clock_line_in = 1'b0;
               data_line_in  = shift_in[3'(3'd7 - bit_in[2:0])];
            end
            i2cbm_pkg::ST_TACK_LO, i2cbm_pkg::ST_RX_LO: begin
               clock_line_in = 1'b0;
               data_line_in  = 1'b1;
            end
            i2cbm_pkg::ST_RACK_LO: begin
               clock_line_in = 1'b0;
               data_line_in  = (bytes_in == 8'd0);
            end
            i2cbm_pkg::ST_STOP_A: begin
               clock_line_in = 1'b0;
               data_line_in  = 1'b0;
            end
            i2cbm_pkg::ST_STOP_C: data_line_in = 1'b1;
            i2cbm_pkg::ST_IDLE: begin
               clock_line_in = 1'b1;
               data_line_in  = 1'b1;
            end
            default: clock_line_in = 1'b1;
         endcase
      end

      rsp.scl_level        = clock_line_in;
      rsp.sda_release      = data_line_in;
      rsp.busy_res         = (state_in != i2cbm_pkg::ST_IDLE);
      rsp.write_byte_taken = taken;
      rsp.read_valid       = rvalid;
      rsp.read_byte        = rbyte;
      rsp.read_last        = rlast;
      rsp.nack_seen        = nack;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= i2cbm_pkg::ST_IDLE;
         stage_ff      <= i2cbm_pkg::STAGE_ADDR_W;
         phase_ff      <= 16'd0;
         bit_ff        <= 4'd0;
         bytes_ff      <= 8'd0;
         shift_ff      <= 8'd0;
         sreg_ff       <= 8'd0;
         sop_ff        <= 1'b0;
         clock_line_ff <= 1'b1;
         data_line_ff  <= 1'b1;
      end else if (step) begin
         state_ff      <= state_in;
         stage_ff      <= stage_in;
         phase_ff      <= phase_in;
         bit_ff        <= bit_in;
         bytes_ff      <= bytes_in;
         shift_ff      <= shift_in;
         sreg_ff       <= sreg_in;
         sop_ff        <= sop_in;
         clock_line_ff <= clock_line_in;
         data_line_ff  <= data_line_in;
      end
   end

   // bus is released whenever the sequencer rests
   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      state_ff == i2cbm_pkg::ST_IDLE |-> clock_line_ff && data_line_ff)
      else $error("bus not released while idle");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= 4'd8)
      else $error("bit index out of range");

   a_taken_starts_tx: assert property (@(posedge clock) disable iff (reset)
      step && rsp.write_byte_taken |=> state_ff == i2cbm_pkg::ST_TX_LO && bit_ff == 4'd0)
      else $error("write byte taken without starting a byte");

   a_read_done_to_ack: assert property (@(posedge clock) disable iff (reset)
      step && rsp.read_valid |=> state_ff == i2cbm_pkg::ST_RACK_LO && phase_ff == 16'd0)
      else $error("received byte not followed by ack segment");

endmodule

`default_nettype wire
